[design/dsa_pkg.sv]
package dsa_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EXEC = 1'b1;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_SUB = 2'd1;
  localparam logic [1:0] FUNC_MUL = 2'd2;
  localparam logic [1:0] FUNC_CMP = 2'd3;

  // Largest number of result digits that the 5-bit result index can carry.
  localparam int MaxOut = 32;

  typedef struct packed {
    logic       op;
    logic [4:0] digit_index;
    logic [3:0] a_digit;
    logic [3:0] b_digit;
    logic [1:0] func;
    logic       a_negative;
    logic       b_negative;
  } dsa_in_t;

  typedef struct packed {
    logic [3:0] result_digit;
    logic [4:0] result_index;
    logic       result_negative;
    logic       last;
    logic       greater;
    logic       equal;
  } dsa_out_t;

  typedef struct packed {
    logic [3:0] a;
    logic [3:0] b;
  } dsa_pair_t;

  typedef enum logic [1:0] {
    MODE_ADD,
    MODE_SUB,
    MODE_MUL
  } dsa_mode_e;

endpackage

[design/dsa_opmem.sv]
module dsa_opmem #(
  parameter int DIGITS = 32,
  parameter int AW     = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [3:0]         a_digit_i,
  input  logic [3:0]         b_digit_i,
  input  logic               re_i,
  input  logic [AW-1:0]      raddr_i,
  output dsa_pkg::dsa_pair_t rdata_o
);
  import dsa_pkg::*;

  dsa_pair_t         mem [DIGITS];
  logic [DIGITS-1:0] valid_q;
  dsa_pair_t         rdata_q;
  dsa_pair_t         wdata;

  // Digits above nine are stored as nine.
  always_comb begin
    wdata.a = (a_digit_i > 4'd9) ? 4'd9 : a_digit_i;
    wdata.b = (b_digit_i > 4'd9) ? 4'd9 : b_digit_i;
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // An entry never loaded since reset reads as zero.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= valid_q[raddr_i] ? mem[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/dsa_wmem.sv]
module dsa_wmem #(
  parameter int DIGITS = 32,
  parameter int AW     = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [3:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [3:0]    rdata_o
);

  logic [3:0] mem [DIGITS];
  logic [3:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/dsa_dunit.sv]
module dsa_dunit (
  input  dsa_pkg::dsa_mode_e mode_i,
  input  logic [3:0]         x_i,
  input  logic [3:0]         y_i,
  input  logic [3:0]         w_i,
  input  logic [3:0]         c_i,
  output logic [3:0]         digit_o,
  output logic [3:0]         carry_o
);
  import dsa_pkg::*;

  logic [7:0] prod;
  logic [6:0] sum;
  logic [4:0] diff;

  assign prod = 8'(x_i) * 8'(y_i);

  always_comb begin
    sum     = '0;
    diff    = '0;
    digit_o = '0;
    carry_o = '0;
    case (mode_i)
      MODE_ADD, MODE_MUL: begin
        if (mode_i == MODE_ADD) begin
          sum = 7'(x_i) + 7'(y_i) + 7'(c_i);
        end else begin
          sum = 7'(8'(w_i) + prod + 8'(c_i));
        end
        // The sum stays below 100, so the tens digit is a count of thresholds passed.
        for (int m = 1; m <= 9; m++) begin
          if (sum >= 7'(10 * m)) begin
            carry_o = 4'(m);
          end
        end
        digit_o = 4'(sum - 7'(carry_o) * 7'd10);
      end
      MODE_SUB: begin
        diff = 5'(x_i) - 5'(y_i) - 5'(c_i);
        if (diff[4]) begin
          digit_o = 4'(diff + 5'd10);
          carry_o = 4'd1;
        end else begin
          digit_o = diff[3:0];
        end
      end
      default: begin
        digit_o = '0;
        carry_o = '0;
      end
    endcase
  end

endmodule

[design/decimal_signed_add_sub_mul_core.sv]
// Channel   Direction  Payload     Transfer
// in        input      dsa_in_t    in_valid_i high, in_stall_o low
// out       output     dsa_out_t   out_valid_o high, out_stall_i low
//
// Every digit step is a read state, then a compute/write state on the digit memories.
// Compare: a magnitude scan, then the flag result. Add or subtract: one digit pass,
// after a magnitude scan when the effective signs differ. Multiply: a clear of the
// work digits, then one row pass per lower-half digit of a. Result digits are read,
// then registered. Reset clears the operands through per-digit valid bits at once.
// The input is stalled while an execute runs; output stall holds the sequencer.
module decimal_signed_add_sub_mul_core #(
  parameter int DIGITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dsa_pkg::dsa_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dsa_pkg::dsa_out_t out_data_o
);
  import dsa_pkg::*;

  localparam int AW       = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int KW       = AW + 1;
  localparam int Half     = DIGITS / 2;
  localparam int OutCount = (DIGITS < MaxOut) ? DIGITS : MaxOut;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CMPRD = 4'd1;
  localparam logic [3:0] S_CMPEX = 4'd2;
  localparam logic [3:0] S_ASRD  = 4'd3;
  localparam logic [3:0] S_ASEX  = 4'd4;
  localparam logic [3:0] S_CLR   = 4'd5;
  localparam logic [3:0] S_MARD  = 4'd6;
  localparam logic [3:0] S_MALD  = 4'd7;
  localparam logic [3:0] S_MRD   = 4'd8;
  localparam logic [3:0] S_MEX   = 4'd9;
  localparam logic [3:0] S_ORD   = 4'd10;
  localparam logic [3:0] S_OWR   = 4'd11;
  localparam logic [3:0] S_COUT  = 4'd12;

  logic [3:0]    state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] row_q, row_d;
  logic [KW-1:0] k_q, k_d;
  logic [3:0]    carry_q, carry_d;
  logic [3:0]    arow_q, arow_d;
  logic [1:0]    func_q, func_d;
  logic          aneg_q, aneg_d;
  logic          bneg_q, bneg_d;
  logic          gtm_q, gtm_d;
  logic          ltm_q, ltm_d;
  logic          out_valid_q, out_valid_d;
  dsa_out_t      out_q, out_d;

  logic          in_xfer;
  logic          out_free;
  logic          rneg;
  logic          cmp_gt;
  logic          cmp_eq;
  logic [KW-1:0] wsum;

  logic          op_we;
  logic          op_re;
  logic [AW-1:0] op_raddr;
  dsa_pair_t     op_rdata;
  logic          w_we;
  logic [AW-1:0] w_waddr;
  logic [3:0]    w_wdata;
  logic          w_re;
  logic [AW-1:0] w_raddr;
  logic [3:0]    w_rdata;

  dsa_mode_e     mode;
  logic [3:0]    ux, uy, udigit, ucarry;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign op_we = in_xfer && (in_data_i.op == OP_LOAD) && (32'(in_data_i.digit_index) < DIGITS);

  dsa_opmem #(.DIGITS(DIGITS), .AW(AW)) u_opmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (op_we),
    .waddr_i   (AW'(in_data_i.digit_index)),
    .a_digit_i (in_data_i.a_digit),
    .b_digit_i (in_data_i.b_digit),
    .re_i      (op_re),
    .raddr_i   (op_raddr),
    .rdata_o   (op_rdata)
  );

  dsa_wmem #(.DIGITS(DIGITS), .AW(AW)) u_wmem (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .re_i    (w_re),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  dsa_dunit u_dunit (
    .mode_i  (mode),
    .x_i     (ux),
    .y_i     (uy),
    .w_i     (w_rdata),
    .c_i     (carry_q),
    .digit_o (udigit),
    .carry_o (ucarry)
  );

  // Sign and flags follow from the stored signs and the magnitude scan.
  always_comb begin
    if (func_q == FUNC_MUL) begin
      rneg = aneg_q ^ bneg_q;
    end else if (aneg_q == bneg_q) begin
      rneg = bneg_q;
    end else begin
      rneg = gtm_q ? aneg_q : bneg_q;
    end
    if (aneg_q != bneg_q) begin
      cmp_gt = !aneg_q;
    end else begin
      cmp_gt = aneg_q ? ltm_q : gtm_q;
    end
    cmp_eq = (aneg_q == bneg_q) && !gtm_q && !ltm_q;
  end

  // Unlike signs subtract the smaller magnitude from the larger.
  always_comb begin
    mode = MODE_ADD;
    ux   = op_rdata.a;
    uy   = op_rdata.b;
    if (state_q == S_MEX) begin
      mode = MODE_MUL;
      ux   = arow_q;
      uy   = (k_q == KW'(Half)) ? 4'd0 : op_rdata.b;
    end else if (aneg_q != bneg_q) begin
      mode = MODE_SUB;
      if (!gtm_q) begin
        ux = op_rdata.b;
        uy = op_rdata.a;
      end
    end
  end

  assign wsum = KW'(row_q) + k_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    row_d       = row_q;
    k_d         = k_q;
    carry_d     = carry_q;
    arow_d      = arow_q;
    func_d      = func_q;
    aneg_d      = aneg_q;
    bneg_d      = bneg_q;
    gtm_d       = gtm_q;
    ltm_d       = ltm_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    op_re       = 1'b0;
    op_raddr    = cnt_q;
    w_we        = 1'b0;
    w_waddr     = cnt_q;
    w_wdata     = udigit;
    w_re        = 1'b0;
    w_raddr     = cnt_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer && in_data_i.op == OP_EXEC) begin
          func_d  = in_data_i.func;
          aneg_d  = in_data_i.a_negative;
          bneg_d  = in_data_i.b_negative ^ (in_data_i.func == FUNC_SUB);
          gtm_d   = 1'b0;
          ltm_d   = 1'b0;
          carry_d = '0;
          if (in_data_i.func == FUNC_MUL) begin
            cnt_d   = '0;
            state_d = S_CLR;
          end else if (in_data_i.func == FUNC_CMP ||
                       in_data_i.a_negative != bneg_d) begin
            cnt_d   = AW'(DIGITS - 1);
            state_d = S_CMPRD;
          end else begin
            cnt_d   = '0;
            state_d = S_ASRD;
          end
        end
      end
      S_CMPRD: begin
        op_re   = 1'b1;
        state_d = S_CMPEX;
      end
      S_CMPEX: begin
        if (!gtm_q && !ltm_q) begin
          gtm_d = op_rdata.a > op_rdata.b;
          ltm_d = op_rdata.a < op_rdata.b;
        end
        if (cnt_q == '0) begin
          state_d = (func_q == FUNC_CMP) ? S_COUT : S_ASRD;
        end else begin
          cnt_d   = cnt_q - 1'b1;
          state_d = S_CMPRD;
        end
      end
      S_ASRD: begin
        op_re   = 1'b1;
        state_d = S_ASEX;
      end
      S_ASEX: begin
        w_we    = 1'b1;
        carry_d = ucarry;
        if (cnt_q == AW'(DIGITS - 1)) begin
          cnt_d   = '0;
          state_d = S_ORD;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_ASRD;
        end
      end
      S_CLR: begin
        w_we    = 1'b1;
        w_wdata = '0;
        if (cnt_q == AW'(DIGITS - 1)) begin
          row_d   = '0;
          state_d = S_MARD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_MARD: begin
        op_re    = 1'b1;
        op_raddr = row_q;
        state_d  = S_MALD;
      end
      S_MALD: begin
        arow_d  = op_rdata.a;
        k_d     = '0;
        carry_d = '0;
        state_d = S_MRD;
      end
      S_MRD: begin
        // One step is fully written back before the next read, so no forwarding.
        op_re    = 1'b1;
        op_raddr = AW'(k_q);
        w_re     = 1'b1;
        w_raddr  = AW'(wsum);
        state_d  = S_MEX;
      end
      S_MEX: begin
        w_we    = 1'b1;
        w_waddr = AW'(wsum);
        carry_d = ucarry;
        if (k_q == KW'(Half)) begin
          if (row_q == AW'(Half - 1)) begin
            cnt_d   = '0;
            state_d = S_ORD;
          end else begin
            row_d   = row_q + 1'b1;
            state_d = S_MARD;
          end
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_MRD;
        end
      end
      S_ORD: begin
        w_re    = 1'b1;
        state_d = S_OWR;
      end
      S_OWR: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.result_digit    = w_rdata;
          out_d.result_index    = 5'(cnt_q);
          out_d.result_negative = rneg;
          out_d.last            = (cnt_q == AW'(OutCount - 1));
          out_d.greater         = 1'b0;
          out_d.equal           = 1'b0;
          if (cnt_q == AW'(OutCount - 1)) begin
            state_d = S_IDLE;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = S_ORD;
          end
        end
      end
      S_COUT: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.result_digit    = '0;
          out_d.result_index    = '0;
          out_d.result_negative = 1'b0;
          out_d.last            = 1'b1;
          out_d.greater         = cmp_gt;
          out_d.equal           = cmp_eq;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      row_q       <= '0;
      k_q         <= '0;
      carry_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      row_q       <= row_d;
      k_q         <= k_d;
      carry_q     <= carry_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    arow_q <= arow_d;
    func_q <= func_d;
    aneg_q <= aneg_d;
    bneg_q <= bneg_d;
    gtm_q  <= gtm_d;
    ltm_q  <= ltm_d;
    out_q  <= out_d;
  end

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MEX |-> k_q <= KW'(Half))
    else $error("multiply step index past the row end");

  a_carry_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MEX || state_q == S_ASEX) |-> carry_q <= 4'd9)
    else $error("digit carry out of range");

  a_mag_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMPEX |=> !(gtm_q && ltm_q))
    else $error("magnitude compare both greater and less");

  a_owr_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OWR && out_free) |=> out_valid_q)
    else $error("result digit not loaded into the output register");

endmodule

[bench/tb_decimal_signed_add_sub_mul_core.sv]
module tb_decimal_signed_add_sub_mul_core;
  import dsa_pkg::*;

  localparam int Digits = 32;
  localparam int HalfDigits = Digits / 2;
  localparam int DrainCycles = 400;
  localparam int StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  dsa_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  dsa_out_t out_data_o;

  decimal_signed_add_sub_mul_core #(.DIGITS(Digits)) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copies of the operand and work digit stores.
  logic [3:0] a_digits [Digits];
  logic [3:0] b_digits [Digits];
  logic [3:0] work_digits [Digits];
  dsa_out_t expected_digits [$];
  int error_count = 0;
  int idle_cycles = 0;
  int loads_sent = 0;
  int execs_sent = 0;
  int digits_checked = 0;
  bit rx_quiet = 1'b0;

  function automatic logic [3:0] pick_gap();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(6, 15));
    if ($urandom_range(0, 2) == 0) return 4'd0;
    return 4'($urandom_range(0, 2));
  endfunction

  function automatic int compare_magnitudes();
    for (int i = Digits - 1; i >= 0; i--) begin
      if (a_digits[i] != b_digits[i]) return (a_digits[i] > b_digits[i]) ? 1 : -1;
    end
    return 0;
  endfunction

  // Updates the shadow digits for a load, or works out and queues an execute's results.
  task automatic predict_transfer(input dsa_in_t item);
    int c;
    int s;
    int carry;
    int j;
    logic rneg;
    logic bneg;
    dsa_out_t res;
    if (item.op == OP_LOAD) begin
      if (item.digit_index < Digits) begin
        a_digits[item.digit_index] = (item.a_digit > 9) ? 4'd9 : item.a_digit;
        b_digits[item.digit_index] = (item.b_digit > 9) ? 4'd9 : item.b_digit;
      end
      return;
    end
    c = compare_magnitudes();
    if (item.func == FUNC_CMP) begin
      res = '0;
      res.last = 1'b1;
      if (item.a_negative != item.b_negative) res.greater = !item.a_negative;
      else if (!item.a_negative) res.greater = (c > 0);
      else res.greater = (c < 0);
      res.equal = (item.a_negative == item.b_negative) && (c == 0);
      expected_digits.push_back(res);
      return;
    end
    if (item.func == FUNC_MUL) begin
      for (int i = 0; i < Digits; i++) work_digits[i] = '0;
      for (int i = 0; i < HalfDigits; i++) begin
        carry = 0;
        for (j = i; j < HalfDigits + i; j++) begin
          s = work_digits[j] + a_digits[i] * b_digits[j - i] + carry;
          carry = s / 10;
          work_digits[j] = 4'(s % 10);
        end
        if (carry != 0 && j < Digits) work_digits[j] = 4'((work_digits[j] + carry) % 10);
      end
      rneg = item.a_negative != item.b_negative;
    end else begin
      bneg = (item.func == FUNC_SUB) ? !item.b_negative : item.b_negative;
      if (item.a_negative == bneg) begin
        carry = 0;
        for (int i = 0; i < Digits; i++) begin
          s = a_digits[i] + b_digits[i] + carry;
          carry = s / 10;
          work_digits[i] = 4'(s % 10);
        end
        rneg = bneg;
      end else begin
        carry = 0;
        for (int i = 0; i < Digits; i++) begin
          s = (c > 0) ? a_digits[i] - b_digits[i] - carry : b_digits[i] - a_digits[i] - carry;
          carry = (s < 0);
          work_digits[i] = 4'((s < 0) ? s + 10 : s);
        end
        rneg = (c > 0) ? item.a_negative : bneg;
      end
    end
    for (int k = 0; k < Digits; k++) begin
      res = '0;
      res.result_digit = work_digits[k];
      res.result_index = 5'(k);
      res.result_negative = rneg;
      res.last = (k == Digits - 1);
      expected_digits.push_back(res);
    end
  endtask

  task automatic report_mismatch(input string what, input dsa_out_t got, input dsa_out_t want);
    error_count++;
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
  endtask

  // Sends one item, with a random gap before it unless the gap is suppressed.
  // Valid stays high after a transfer until the next gap or a drain, so a
  // back-to-back item only replaces the payload.
  task automatic send_item(input dsa_in_t item, input bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    predict_transfer(item);
    if (item.op == OP_LOAD) loads_sent++;
    else execs_sent++;
  endtask

  task automatic load_digit(input int idx, input logic [3:0] ad, input logic [3:0] bd);
    dsa_in_t item;
    item = '0;
    item.op = OP_LOAD;
    item.digit_index = 5'(idx);
    item.a_digit = ad;
    item.b_digit = bd;
    item.func = 2'($urandom);
    item.a_negative = 1'($urandom);
    item.b_negative = 1'($urandom);
    send_item(item, $urandom_range(0, 3) == 0);
  endtask

  task automatic run_op(input logic [1:0] fn, input logic an, input logic bn);
    dsa_in_t item;
    item = '0;
    item.op = OP_EXEC;
    item.digit_index = 5'($urandom);
    item.a_digit = 4'($urandom);
    item.b_digit = 4'($urandom);
    item.func = fn;
    item.a_negative = an;
    item.b_negative = bn;
    send_item(item);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_zero_operands();
    for (int f = 0; f < 4; f++) run_op(2'(f), 1'b0, 1'b1);
    run_op(FUNC_CMP, 1'b0, 1'b0);
    run_op(FUNC_CMP, 1'b1, 1'b0);
  endtask

  task automatic test_digit_extremes();
    load_digit(0, 4'd9, 4'd9);
    load_digit(31, 4'd15, 4'd12);
    load_digit(15, 4'd10, 4'd0);
    load_digit(1, 4'd0, 4'd15);
    run_op(FUNC_ADD, 1'b0, 1'b0);
    run_op(FUNC_SUB, 1'b1, 1'b1);
    run_op(FUNC_SUB, 1'b0, 1'b1);
    run_op(FUNC_MUL, 1'b1, 1'b1);
    run_op(FUNC_CMP, 1'b1, 1'b1);
  endtask

  task automatic test_equal_magnitudes();
    for (int i = 0; i < 4; i++) load_digit(i, 4'(i + 5), 4'(i + 5));
    load_digit(31, 4'd0, 4'd0);
    load_digit(15, 4'd0, 4'd0);
    run_op(FUNC_ADD, 1'b0, 1'b1);
    run_op(FUNC_SUB, 1'b1, 1'b1);
    run_op(FUNC_CMP, 1'b1, 1'b1);
  endtask

  task automatic test_random_operations(input int budget);
    int n;
    int lo;
    int hi;
    while (budget > 0) begin
      // Mostly a run of loads into a random window, then one or two executes.
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          load_digit($urandom_range(0, 31), 4'($urandom), 4'($urandom));
        end else begin
          lo = ($urandom_range(0, 1) == 0) ? 0 : 16;
          hi = lo + 15;
          load_digit($urandom_range(lo, hi), 4'($urandom_range(0, 9)),
                     4'($urandom_range(0, 9)));
        end
      end
      budget -= n;
      n = $urandom_range(1, 2);
      for (int i = 0; i < n; i++) begin
        run_op(2'($urandom), 1'($urandom), 1'($urandom));
      end
      budget -= n;
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
  endtask

  // Output side: random stalls, and each transfer checked against the queue.
  always @(posedge clk_i) begin
    dsa_out_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_digits.size() == 0) begin
        report_mismatch("unexpected result", out_data_o, '0);
      end else begin
        want = expected_digits.pop_front();
        digits_checked++;
        if (out_data_o.result_digit !== want.result_digit)
          report_mismatch("result_digit", out_data_o, want);
        if (out_data_o.result_index !== want.result_index)
          report_mismatch("result_index", out_data_o, want);
        if (out_data_o.result_negative !== want.result_negative)
          report_mismatch("result_negative", out_data_o, want);
        if (out_data_o.last !== want.last) report_mismatch("last", out_data_o, want);
        if (out_data_o.greater !== want.greater) report_mismatch("greater", out_data_o, want);
        if (out_data_o.equal !== want.equal) report_mismatch("equal", out_data_o, want);
      end
    end
    if (rx_quiet) out_stall_i <= 1'b0;
    else out_stall_i <= (pick_gap() > 4'd1);
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Timeout with %0d results pending", expected_digits.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < Digits; i++) begin
      a_digits[i] = '0;
      b_digits[i] = '0;
      work_digits[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_operands();
    test_digit_extremes();
    wait_drained();
    test_equal_magnitudes();
    rx_quiet = 1'b1;
    test_random_operations(60);
    rx_quiet = 1'b0;
    test_random_operations(330);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d digit loads and %0d executes of add, subtract, multiply, compare;",
             loads_sent, execs_sent);
    $display("%0d result transfers were checked field by field.", digits_checked);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/dsa_pkg.sv
design/dsa_opmem.sv
design/dsa_wmem.sv
design/dsa_dunit.sv
design/decimal_signed_add_sub_mul_core.sv
bench/tb_decimal_signed_add_sub_mul_core.sv
